@@ hdl/swb_pkg.sv @@
// ----------------------------------------------------------------------------
// swb_pkg - shared definitions for the base-1626 seed word codec
// Field widths, command codes and the default word-list size.
// ----------------------------------------------------------------------------
package swb_pkg;

    // Field widths of the request and response beats
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned IDX_IN_W   = 12;
    localparam int unsigned IDX_OUT_W  = 11;

    // Default number of words in the word list
    localparam int unsigned LIST_SIZE_DEFAULT = 1626;

    // Command codes
    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } t_cmd;

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [IDX_IN_W-1:0]  t_idx_in;
    typedef logic [IDX_OUT_W-1:0] t_idx_out;

endpackage

@@ hdl/swb_if.sv @@
// ----------------------------------------------------------------------------
// swb_if - request and response channels of the seed word codec
// Valid/ready channels; a beat moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface swb_req_if;
    import swb_pkg::*;

    logic    valid;
    logic    ready;
    t_cmd    cmd;
    t_word   seed_word;
    t_idx_in first_index;
    t_idx_in second_index;
    t_idx_in third_index;

    modport source (
        output valid, cmd, seed_word, first_index, second_index, third_index,
        input  ready
    );
    modport sink (
        input  valid, cmd, seed_word, first_index, second_index, third_index,
        output ready
    );
endinterface

interface swb_rsp_if;
    import swb_pkg::*;

    logic     valid;
    logic     ready;
    t_word    word_out;
    t_idx_out first_out;
    t_idx_out second_out;
    t_idx_out third_out;
    logic     ok;

    modport source (
        output valid, word_out, first_out, second_out, third_out, ok,
        input  ready
    );
    modport sink (
        input  valid, word_out, first_out, second_out, third_out, ok,
        output ready
    );
endinterface

@@ hdl/swb_recip_div.sv @@
// ----------------------------------------------------------------------------
// swb_recip_div - registered division of a 32-bit word by a constant
// Multiplies by a rounded-up reciprocal and keeps the upper bits, which gives
// the exact floor quotient for every 32-bit dividend. One register stage.
// ----------------------------------------------------------------------------
module swb_recip_div #(
    parameter logic [63:0] DIVISOR = 64'(swb_pkg::LIST_SIZE_DEFAULT)
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  swb_pkg::t_word      i_x,
    output swb_pkg::t_word      o_q
);
    import swb_pkg::*;

    localparam int unsigned LOG_D = $clog2(DIVISOR);
    localparam int unsigned SHIFT = WORD_W + LOG_D;
    // Divisors beyond the word range always give a zero quotient
    localparam bit BIG_D = (DIVISOR > 64'hFFFF_FFFF);
    localparam logic [127:0] RECIP_FULL =
        ((128'd1 << SHIFT) + {64'd0, DIVISOR} - 128'd1) / {64'd0, DIVISOR};
    localparam logic [WORD_W:0] RECIP = BIG_D ? '0 : RECIP_FULL[WORD_W:0];

    logic [2*WORD_W:0] w_prod;
    t_word             n_q;
    t_word             r_q;

    // Scale by the reciprocal and drop the fraction
    assign w_prod = {{(WORD_W+1){1'b0}}, i_x} * {{WORD_W{1'b0}}, RECIP};
    assign n_q    = WORD_W'(w_prod >> SHIFT);

    // Hold the quotient while the stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

@@ hdl/seed_word_base1626_codec.sv @@
// ----------------------------------------------------------------------------
// seed_word_base1626_codec - seed word to word-index group codec
// Encodes a 32-bit seed word into three word-list indices, or decodes three
// indices back into the seed word and checks the result.
//
//   channel | dir | beat payload
//   --------+-----+--------------------------------------------------------
//   i_req   | in  | cmd, seed_word, first_index, second_index, third_index
//   o_rsp   | out | word_out, first_out, second_out, third_out, ok
//
// One beat in and one beat out per cycle while the receiver is ready; the stages are
// index residues, two multiplies, the word sum, the reciprocal multipliers,
// the remainder multiply-subtract and the final modular adds.
// Each stage carries its own valid bit and loads when it is empty or the
// stage after it moves on, so a stall holds every beat and bubbles close up.
// Reset (synchronous, active low) clears only the valid bits.
// ----------------------------------------------------------------------------
module seed_word_base1626_codec #(
    parameter int unsigned LIST_SIZE = swb_pkg::LIST_SIZE_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    swb_req_if.sink       i_req,
    swb_rsp_if.source     o_rsp
);
    import swb_pkg::*;

    localparam int unsigned RES_W = $clog2(LIST_SIZE);
    localparam logic [63:0] DIV1  = 64'(LIST_SIZE);
    localparam logic [63:0] DIV2  = DIV1 * DIV1;
    localparam logic [63:0] DIV3  = DIV2 * DIV1;
    localparam t_word       N_W   = WORD_W'(LIST_SIZE);
    localparam t_word       N2_W  = WORD_W'(DIV2);
    localparam logic [IDX_IN_W:0] N_IDX = (IDX_IN_W+1)'(LIST_SIZE);
    localparam logic [RES_W:0]    N_RES = (RES_W+1)'(LIST_SIZE);

    // Stage handshake
    logic [6:1] r_v;
    logic [6:1] w_en;

    // Stage 1: range check and index differences
    t_cmd              r1_cmd;
    t_word             r1_x;
    t_idx_in           r1_a;
    logic              r1_inrange;
    logic [RES_W-1:0]  r1_d1;
    logic [RES_W-1:0]  r1_d2;
    logic [IDX_IN_W:0] w_s1;
    logic [IDX_IN_W:0] w_s2;
    logic [RES_W-1:0]  n1_d1;
    logic [RES_W-1:0]  n1_d2;
    logic              n1_inrange;

    // Stage 2: weighted terms
    t_cmd    r2_cmd;
    t_word   r2_x;
    t_idx_in r2_a;
    logic    r2_inrange;
    t_word   r2_t1;
    t_word   r2_t2;

    // Stage 3: common word
    t_cmd    r3_cmd;
    t_word   r3_x;
    t_idx_in r3_a;
    logic    r3_inrange;
    t_word   n3_x;

    // Stage 4: quotients (inside the dividers) and side band
    t_cmd    r4_cmd;
    t_word   r4_x;
    t_idx_in r4_a;
    logic    r4_inrange;
    t_word   w_q1;
    t_word   w_q2;
    t_word   w_q3;

    // Stage 5: remainders
    t_cmd             r5_cmd;
    t_word            r5_x;
    t_idx_in          r5_a;
    logic             r5_inrange;
    logic [RES_W-1:0] r5_r1;
    logic [RES_W-1:0] r5_r2;
    logic [RES_W-1:0] r5_r3;

    // Stage 6: output register
    t_cmd             r6_cmd;
    t_word            r6_word;
    t_idx_out         r6_first;
    t_idx_out         r6_second;
    t_idx_out         r6_third;
    logic             r6_ok;
    logic [RES_W:0]   w_sum_b;
    logic [RES_W:0]   w_b;
    logic [RES_W:0]   w_sum_c;
    logic [RES_W:0]   w_c;
    logic             w_dec_ok;

    // Load a stage when it is empty or its contents move on
    always_comb begin
        w_en[6] = !r_v[6] || o_rsp.ready;
        for (int k = 5; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_req.ready = w_en[1];

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= i_req.valid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: differences of neighbouring indices modulo the list size
    always_comb begin
        n1_inrange = ({1'b0, i_req.first_index}  < N_IDX) &&
                     ({1'b0, i_req.second_index} < N_IDX) &&
                     ({1'b0, i_req.third_index}  < N_IDX);
        w_s1 = N_IDX - {1'b0, i_req.first_index} + {1'b0, i_req.second_index};
        w_s2 = N_IDX - {1'b0, i_req.second_index} + {1'b0, i_req.third_index};
        n1_d1 = RES_W'((w_s1 >= N_IDX) ? (w_s1 - N_IDX) : w_s1);
        n1_d2 = RES_W'((w_s2 >= N_IDX) ? (w_s2 - N_IDX) : w_s2);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_cmd     <= i_req.cmd;
            r1_x       <= i_req.seed_word;
            r1_a       <= i_req.first_index;
            r1_inrange <= n1_inrange;
            r1_d1      <= n1_d1;
            r1_d2      <= n1_d2;
        end
    end

    // Stage 2: weight the differences by N and N squared, modulo 2^32
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_cmd     <= r1_cmd;
            r2_x       <= r1_x;
            r2_a       <= r1_a;
            r2_inrange <= r1_inrange;
            r2_t1      <= N_W * WORD_W'(r1_d1);
            r2_t2      <= N2_W * WORD_W'(r1_d2);
        end
    end

    // Stage 3: pick the seed word or assemble the decoded one
    assign n3_x = (r2_cmd == CMD_DECODE) ? (WORD_W'(r2_a) + r2_t1 + r2_t2) : r2_x;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_cmd     <= r2_cmd;
            r3_x       <= n3_x;
            r3_a       <= r2_a;
            r3_inrange <= r2_inrange;
        end
    end

    // Stage 4: quotients by N, N squared and N cubed
    swb_recip_div #(.DIVISOR(DIV1)) u_div1 (
        .i_clk (i_clk), .i_en (w_en[4]), .i_x (r3_x), .o_q (w_q1)
    );
    swb_recip_div #(.DIVISOR(DIV2)) u_div2 (
        .i_clk (i_clk), .i_en (w_en[4]), .i_x (r3_x), .o_q (w_q2)
    );
    swb_recip_div #(.DIVISOR(DIV3)) u_div3 (
        .i_clk (i_clk), .i_en (w_en[4]), .i_x (r3_x), .o_q (w_q3)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_cmd     <= r3_cmd;
            r4_x       <= r3_x;
            r4_a       <= r3_a;
            r4_inrange <= r3_inrange;
        end
    end

    // Stage 5: base-N digits from consecutive quotients
    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_cmd     <= r4_cmd;
            r5_x       <= r4_x;
            r5_a       <= r4_a;
            r5_inrange <= r4_inrange;
            r5_r1      <= RES_W'(r4_x - w_q1 * N_W);
            r5_r2      <= RES_W'(w_q1 - w_q2 * N_W);
            r5_r3      <= RES_W'(w_q2 - w_q3 * N_W);
        end
    end

    // Stage 6: chain the digits into indices, or check the decoded word
    always_comb begin
        w_sum_b  = {1'b0, r5_r2} + {1'b0, r5_r1};
        w_b      = (w_sum_b >= N_RES) ? (w_sum_b - N_RES) : w_sum_b;
        w_sum_c  = {1'b0, r5_r3} + w_b;
        w_c      = (w_sum_c >= N_RES) ? (w_sum_c - N_RES) : w_sum_c;
        w_dec_ok = r5_inrange && (IDX_IN_W'(r5_r1) == r5_a);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_cmd <= r5_cmd;
            if (r5_cmd == CMD_DECODE) begin
                r6_word   <= w_dec_ok ? r5_x : '0;
                r6_first  <= '0;
                r6_second <= '0;
                r6_third  <= '0;
                r6_ok     <= w_dec_ok;
            end else begin
                r6_word   <= '0;
                r6_first  <= IDX_OUT_W'(r5_r1);
                r6_second <= IDX_OUT_W'(w_b);
                r6_third  <= IDX_OUT_W'(w_c);
                r6_ok     <= 1'b1;
            end
        end
    end

    assign o_rsp.valid      = r_v[6];
    assign o_rsp.word_out   = r6_word;
    assign o_rsp.first_out  = r6_first;
    assign o_rsp.second_out = r6_second;
    assign o_rsp.third_out  = r6_third;
    assign o_rsp.ok         = r6_ok;

    // Encode beats always leave flagged good
    a_encode_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[6] && (r6_cmd == CMD_ENCODE)) |-> r6_ok)
        else $error("encode beat left with ok low");

    // Encode digits stay below the list size
    a_digits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && (r5_cmd == CMD_ENCODE)) |->
        ((r5_r1 < N_RES) && (r5_r2 < N_RES) && (r5_r3 < N_RES)))
        else $error("base-N digit out of range");

    // A stalled output holds the beat behind it
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && r_v[6] && !o_rsp.ready) |=> (r_v[5] && $stable(r5_x)))
        else $error("stage five beat lost under stall");

    // A new output beat comes from a filled stage five
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v[6]) |-> $past(r_v[5]))
        else $error("output beat without a source");

endmodule

@@ tb/sv/tb_seed_word_base1626_codec.sv @@
// ----------------------------------------------------------------------------
// tb_seed_word_base1626_codec - self-checking bench for the seed word codec
// Drives encode and decode beats through the request channel. Each accepted
// beat is predicted by a model of the base-1626 group arithmetic, and every
// response beat is checked field by field against the oldest prediction.
// Sender bursts and receiver stalls vary throughout, including one long
// receiver hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_seed_word_base1626_codec;
    timeunit 1ns;
    timeprecision 1ps;

    import swb_pkg::*;

    localparam int unsigned LIST_N       = LIST_SIZE_DEFAULT;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned LONG_STALL   = 300;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned RANDOM_BEATS = 1600;
    localparam int unsigned PRESS_BEATS  = 60;
    localparam int unsigned MAX_PRINTS   = 40;

    typedef struct packed {
        t_word    word;
        t_idx_out first_idx;
        t_idx_out second_idx;
        t_idx_out third_idx;
        logic     ok;
    } t_group_result;

    logic clk = 1'b0;
    logic rst_n;

    swb_req_if req_if ();
    swb_rsp_if rsp_if ();

    seed_word_base1626_codec #(
        .LIST_SIZE (LIST_N)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    t_group_result group_results_due[$];
    int unsigned   mismatch_count;
    int unsigned   cycle_count;
    int unsigned   burst_left;
    int unsigned   encode_beats;
    int unsigned   decode_beats;
    int unsigned   rejected_decodes;
    bit            sender_steady;
    bit            long_stall_req;
    bit            long_stall_active;

    // Clock: 20 ns period
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Group arithmetic over a list of LIST_N words
    function automatic t_group_result predict_group(t_cmd cmd, t_word seed,
                                                    t_idx_in a_in, t_idx_in b_in,
                                                    t_idx_in c_in);
        longint unsigned n;
        longint unsigned x;
        longint unsigned q;
        longint unsigned a;
        longint unsigned b;
        longint unsigned c;
        t_group_result   r;
        n = LIST_N;
        r = '0;
        if (cmd == CMD_ENCODE) begin
            x = seed;
            q = x / n;
            a = x % n;
            b = (q + a) % n;
            c = (q / n + b) % n;
            r.first_idx  = t_idx_out'(a);
            r.second_idx = t_idx_out'(b);
            r.third_idx  = t_idx_out'(c);
            r.ok         = 1'b1;
        end else begin
            a = a_in;
            b = b_in;
            c = c_in;
            // reject any index off the end of the list
            if (a >= n || b >= n || c >= n)
                return r;
            x = a + n * ((n - a + b) % n) + n * n * ((n - b + c) % n);
            x = x & 64'hFFFF_FFFF;
            // a wrapped sum no longer carries the first index
            if (x % n != a)
                return r;
            r.word = t_word'(x);
            r.ok   = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s got 0x%08h want 0x%08h", $realtime, what, got, want);
    endtask

    // Offer one beat, honouring the burst/gap pacing, and log its prediction
    task automatic send_group(t_cmd cmd, t_word seed, t_idx_in a, t_idx_in b,
                              t_idx_in c);
        int unsigned   gap;
        t_group_result due;
        if (!sender_steady && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        req_if.valid        <= 1'b1;
        req_if.cmd          <= cmd;
        req_if.seed_word    <= seed;
        req_if.first_index  <= a;
        req_if.second_index <= b;
        req_if.third_index  <= c;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        due = predict_group(cmd, seed, a, b, c);
        group_results_due.push_back(due);
        if (cmd == CMD_ENCODE) begin
            encode_beats++;
        end else begin
            decode_beats++;
            if (!due.ok)
                rejected_decodes++;
        end
    endtask

    // Hold the sender until every predicted beat has come back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (group_results_due.size() != 0);
    endtask

    // Encode a seed word with the model and send its indices as a decode beat
    task automatic send_round_trip(t_word seed);
        t_group_result enc;
        enc = predict_group(CMD_ENCODE, seed, '0, '0, '0);
        send_group(CMD_DECODE, t_word'($urandom()), t_idx_in'(enc.first_idx),
                   t_idx_in'(enc.second_idx), t_idx_in'(enc.third_idx));
    endtask

    function automatic t_word pick_seed_word();
        case ($urandom_range(0, 5))
            0: return t_word'($urandom_range(0, LIST_N * LIST_N));
            1: return 32'hFFFF_FFFF - t_word'($urandom_range(0, 5000));
            2: return t_word'(LIST_N) * t_word'($urandom_range(0, 2641000))
                      + t_word'($urandom_range(0, 2));
            default: return t_word'($urandom());
        endcase
    endfunction

    function automatic t_idx_in pick_index();
        case ($urandom_range(0, 4))
            0: return t_idx_in'($urandom_range(LIST_N - 3, LIST_N + 2));
            1: return t_idx_in'($urandom_range(0, 4095));
            default: return t_idx_in'($urandom_range(0, LIST_N - 1));
        endcase
    endfunction

    task automatic test_encode_edges();
        send_group(CMD_ENCODE, 32'h0000_0000, 12'hFFF, 12'hFFF, 12'hFFF);
        send_group(CMD_ENCODE, 32'h0000_0001, '0, '0, '0);
        send_group(CMD_ENCODE, t_word'(LIST_N - 1), '0, '0, '0);
        send_group(CMD_ENCODE, t_word'(LIST_N), '0, '0, '0);
        send_group(CMD_ENCODE, t_word'(LIST_N * LIST_N - 1), '0, '0, '0);
        send_group(CMD_ENCODE, t_word'(LIST_N * LIST_N), '0, '0, '0);
        send_group(CMD_ENCODE, 32'h8000_0000, '0, '0, '0);
        send_group(CMD_ENCODE, 32'hFFFF_FFFF, '0, '0, '0);
        wait_drained();
    endtask

    task automatic test_decode_edges();
        // all zero, then the top of the list
        send_group(CMD_DECODE, 32'hFFFF_FFFF, 12'd0, 12'd0, 12'd0);
        send_group(CMD_DECODE, '0, t_idx_in'(LIST_N - 1), t_idx_in'(LIST_N - 1),
                   t_idx_in'(LIST_N - 1));
        // each index just off the end, then every bit set
        send_group(CMD_DECODE, '0, t_idx_in'(LIST_N), 12'd0, 12'd0);
        send_group(CMD_DECODE, '0, 12'd0, t_idx_in'(LIST_N), 12'd0);
        send_group(CMD_DECODE, '0, 12'd0, 12'd0, t_idx_in'(LIST_N));
        send_group(CMD_DECODE, '0, 12'hFFF, 12'hFFF, 12'hFFF);
        // in range but the sum wraps past 32 bits and fails the check
        send_group(CMD_DECODE, '0, 12'd0, 12'd0, t_idx_in'(LIST_N - 1));
        // first index above zero with a wrapped middle difference, no overflow
        send_group(CMD_DECODE, '0, 12'd1, 12'd0, 12'd0);
        send_round_trip(32'hFFFF_FFFF);
        send_round_trip(32'h0000_0000);
        send_round_trip(32'h1234_5678);
        wait_drained();
    endtask

    task automatic test_random_mix();
        int unsigned k;
        for (k = 0; k < RANDOM_BEATS; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    send_group(CMD_ENCODE, pick_seed_word(),
                               t_idx_in'($urandom_range(0, 4095)),
                               t_idx_in'($urandom_range(0, 4095)),
                               t_idx_in'($urandom_range(0, 4095)));
                4, 5, 6:
                    send_round_trip(pick_seed_word());
                default:
                    send_group(CMD_DECODE, t_word'($urandom()), pick_index(),
                               pick_index(), pick_index());
            endcase
        end
        wait_drained();
    endtask

    // Keep offering back to back while the receiver holds off
    task automatic test_backpressure();
        int unsigned k;
        sender_steady  = 1'b1;
        long_stall_req = 1'b1;
        wait (long_stall_active);
        for (k = 0; k < PRESS_BEATS; k++) begin
            if (k[0])
                send_round_trip(pick_seed_word());
            else
                send_group(CMD_ENCODE, pick_seed_word(), '0, '0, '0);
        end
        sender_steady = 1'b0;
        wait_drained();
    endtask

    // Receiver: own stall pattern, plus one long hold-off on request
    initial begin : rsp_sink
        int unsigned sink_cycle;
        sink_cycle = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            sink_cycle++;
            if (long_stall_req) begin
                long_stall_active = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                long_stall_req    = 1'b0;
                long_stall_active = 1'b0;
                rsp_if.ready <= 1'b1;
            end else begin
                case ((sink_cycle >> 8) % 4)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    2: rsp_if.ready <= ((sink_cycle % 5) < 3);
                    default: rsp_if.ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // Check each response beat against the oldest prediction
    always @(posedge clk) begin
        t_group_result due;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (group_results_due.size() == 0) begin
                report_mismatch("response beat with nothing due", rsp_if.word_out, '0);
            end else begin
                due = group_results_due.pop_front();
                if (rsp_if.word_out !== due.word)
                    report_mismatch("word_out", rsp_if.word_out, due.word);
                if (rsp_if.first_out !== due.first_idx)
                    report_mismatch("first_out", 32'(rsp_if.first_out), 32'(due.first_idx));
                if (rsp_if.second_out !== due.second_idx)
                    report_mismatch("second_out", 32'(rsp_if.second_out),
                                    32'(due.second_idx));
                if (rsp_if.third_out !== due.third_idx)
                    report_mismatch("third_out", 32'(rsp_if.third_out), 32'(due.third_idx));
                if (rsp_if.ok !== due.ok)
                    report_mismatch("ok", 32'(rsp_if.ok), 32'(due.ok));
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still due", cycle_count,
                     group_results_due.size());
            $display("tb_seed_word_base1626_codec NOT OK");
            $finish;
        end
    end

    initial begin : main
        mismatch_count    = 0;
        cycle_count       = 0;
        burst_left        = 0;
        encode_beats      = 0;
        decode_beats      = 0;
        rejected_decodes  = 0;
        sender_steady     = 1'b0;
        long_stall_req    = 1'b0;
        long_stall_active = 1'b0;
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.cmd          = CMD_ENCODE;
        req_if.seed_word    = '0;
        req_if.first_index  = '0;
        req_if.second_index = '0;
        req_if.third_index  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_encode_edges();
        test_decode_edges();
        test_backpressure();
        test_random_mix();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (group_results_due.size() != 0)
            report_mismatch("beats never returned", group_results_due.size(), 0);
        $display("Covered %0d encode and %0d decode beats (%0d rejected decodes),",
                 encode_beats, decode_beats, rejected_decodes);
        $display("with random bursts and stalls, a %0d-cycle receiver hold-off and drains.",
                 LONG_STALL);
        if (mismatch_count == 0) begin
            $display("tb_seed_word_base1626_codec OK");
        end else begin
            $display("tb_seed_word_base1626_codec NOT OK");
        end
        $finish;
    end

endmodule
